// ===== rtl/core/itoa_pkg.sv =====
`default_nettype none

package itoa_pkg;

   // width of the signed input value
   localparam int VALUE_BITS = 32;
   localparam int RADIX_W    = 5;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;  // 'A'
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;  // '-'
   localparam logic [DIGIT_W-1:0] DIGIT_NINE = DIGIT_W'(9);
   localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [RADIX_W-1:0]           radix;
   } itoa_req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } itoa_rsp_type;

   // quotient bit handed from one digit cell to the next
   typedef struct packed {
      logic valid;
      logic carry;
   } itoa_link_type;

   // broadcast control to every digit cell
   typedef struct packed {
      logic clear;
      logic shift;
   } itoa_ctrl_type;

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_code(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] res;
      if (d > DIGIT_NINE) begin
         res = CHAR_UPPER + CHAR_W'(d - DIGIT_TEN);
      end else begin
         res = CHAR_ZERO + CHAR_W'(d);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/itoa_digit_cell.sv =====
`default_nettype none

// one digit position: a bit-serial remainder by the radix, the quotient
// bit stream goes on, registered, to the next position
module itoa_digit_cell
   import itoa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire itoa_ctrl_type      ctrl,
   input  wire logic [RADIX_W-1:0] radix,
   input  wire itoa_link_type      link_in,
   input  wire logic [DIGIT_W-1:0] shift_in,
   output      itoa_link_type      link_out,
   output      logic [DIGIT_W-1:0] digit
);

   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic               valid_ff;
   logic               carry_ff;
   logic [RADIX_W-1:0] trial;
   logic [RADIX_W-1:0] diff;
   logic               ge;

   // double and add the incoming bit, subtract the radix once if it fits
   assign trial = {digit_ff, link_in.carry};
   assign ge    = (trial >= radix);
   assign diff  = trial - radix;

   always_comb begin
      priority if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.shift) begin
         digit_in = shift_in;
      end else if (link_in.valid) begin
         digit_in = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
      carry_ff <= ge;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= link_in.valid;
      end
   end

   assign link_out.valid = valid_ff;
   assign link_out.carry = carry_ff;
   assign digit          = digit_ff;

endmodule

`default_nettype wire

// ===== rtl/core/integer_to_ascii_radix_core.sv =====
`default_nettype none

// Converts a signed VALUE_BITS-bit integer to text in a radix from 2 to 16
// (out-of-range radix codes saturate), most significant character first, with
// a leading '-' for negative values and no leading zeros; zero gives "0".
// A transfer is taken when start is high and busy is low. Each character is
// shown on rsp_data for one cycle with rsp_valid high; the receiver cannot
// stall, and last_char marks the final character. The magnitude is shifted
// MSB first into a row of VALUE_BITS digit cells, each cell passing its
// quotient bit on to its upper neighbor through a register; the digits are
// then shifted out of the top cell one per cycle. busy stays high through
// conversion and shift-out, so a new item is taken only after the last one
// is through. The '-' comes out during conversion; the last character
// appears in the first cycle with busy low.
module integer_to_ascii_radix_core
   import itoa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output      logic         busy,
   input  wire itoa_req_type req_data,
   output      logic         rsp_valid,
   output      itoa_rsp_type rsp_data
);

   localparam int CNT_W = $clog2(2 * VALUE_BITS);
   localparam logic [CNT_W-1:0] FEED_LAST = CNT_W'(VALUE_BITS - 1);
   localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(2 * VALUE_BITS - 2);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic                  neg_ff, neg_in;
   logic                  started_ff, started_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   itoa_rsp_type          rsp_ff, rsp_in;

   logic                  accept;
   logic [VALUE_BITS-1:0] raw;
   itoa_ctrl_type         ctrl;
   itoa_link_type         link [VALUE_BITS+1];
   logic [DIGIT_W-1:0]    digit [VALUE_BITS];
   logic [DIGIT_W-1:0]    digit_below [VALUE_BITS];
   logic [DIGIT_W-1:0]    top_digit;
   logic                  emit_digit;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign raw       = req_data.value;
   assign top_digit = digit[VALUE_BITS-1];

   assign ctrl.clear = accept;
   assign ctrl.shift = (state_ff == ST_OUT);

   // feed the magnitude MSB first into the lowest cell
   assign link[0].valid = (state_ff == ST_CONV) && (cnt_ff <= FEED_LAST);
   assign link[0].carry = mag_ff[VALUE_BITS-1];

   genvar gi;
   generate
      for (gi = 0; gi < VALUE_BITS; gi++) begin : g_cell
         if (gi == 0) begin : g_low
            assign digit_below[gi] = '0;
         end else begin : g_up
            assign digit_below[gi] = digit[gi-1];
         end
         itoa_digit_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .radix    (radix_ff),
            .link_in  (link[gi]),
            .shift_in (digit_below[gi]),
            .link_out (link[gi+1]),
            .digit    (digit[gi])
         );
      end
   endgenerate

   // leading zeros are dropped, but the units digit always goes out
   assign emit_digit = (state_ff == ST_OUT) &&
                       (started_ff || (top_digit != '0) || (cnt_ff == FEED_LAST));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mag_in       = mag_ff;
      radix_in     = radix_ff;
      neg_in       = neg_ff;
      started_in   = started_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in   = ST_CONV;
               cnt_in     = '0;
               neg_in     = raw[VALUE_BITS-1];
               mag_in     = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
               radix_in   = clamp_radix(req_data.radix);
               started_in = 1'b0;
            end
         end
         ST_CONV: begin
            mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
            if ((cnt_ff == '0) && neg_ff) begin
               rsp_valid_in     = 1'b1;
               rsp_in.char_code = CHAR_MINUS;
               rsp_in.last_char = 1'b0;
            end
            if (cnt_ff == CONV_LAST) begin
               state_in = ST_OUT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_OUT: begin
            if (emit_digit) begin
               rsp_valid_in     = 1'b1;
               rsp_in.char_code = digit_code(top_digit);
               rsp_in.last_char = (cnt_ff == FEED_LAST);
               started_in       = 1'b1;
            end
            if (cnt_ff == FEED_LAST) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      radix_ff <= radix_in;
      neg_ff   <= neg_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CONV) && (cnt_ff == '0))
      else $error("accepted transfer did not start conversion");

   a_no_top_carry: assert property (@(posedge clock) disable iff (reset)
      link[VALUE_BITS].valid |-> !link[VALUE_BITS].carry)
      else $error("magnitude overflowed the digit row");

   a_row_quiet_on_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> !link[VALUE_BITS-1].valid)
      else $error("digit row still converting while shifting out");

   a_last_then_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_char) |=> !rsp_valid)
      else $error("character transfer right after the last character");
`endif

endmodule

`default_nettype wire
